// ===== design/tile_grid_pixel_renderer_macros.svh =====
// Assertion macros shared by the tile grid pixel renderer modules.
`ifndef TILE_GRID_PIXEL_RENDERER_MACROS_SVH
`define TILE_GRID_PIXEL_RENDERER_MACROS_SVH

// Implication that must hold in the same cycle.
`define TGPR_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked a fixed number of cycles after the trigger.
`define TGPR_ASSERT_LATER(name, clk, rst, ante, dly, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error(msg);

// Condition that must never be seen.
`define TGPR_ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

// ===== design/tgpr_pkg.sv =====
// Shared constants, palette and types of the tile grid pixel renderer.
`timescale 1ns / 1ps
package tgpr_pkg;

   // Grid geometry.
   localparam int GRID_COLS = 94;
   localparam int GRID_ROWS = 52;
   localparam int CELL_W    = 10;
   localparam int CELL_H    = 10;
   localparam int BORDER    = 10;

   localparam int STORE_DEPTH = GRID_COLS * GRID_ROWS;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   // Field widths.
   localparam int COORD_W   = 12;
   localparam int COL_W     = 7;
   localparam int ROW_W     = 6;
   localparam int STATE_W   = 4;
   localparam int ARGB_W    = 32;
   localparam int FRAME_W   = 12;
   localparam int CSR_IDX_W = 1;

   // Grid index width covers up to 256 columns or rows.
   localparam int IDX_W = 8;
   localparam int CMP_W = IDX_W + 1;
   localparam int MUL_W = IDX_W + CMP_W;

   // Reciprocal division: the estimate is low by at most one.
   localparam int DIV_SHIFT = 24;
   localparam int RECIP_W   = 24;
   localparam int PROD_W    = COORD_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_X = RECIP_W'((1 << DIV_SHIFT) / CELL_W);
   localparam logic [RECIP_W-1:0] RECIP_Y = RECIP_W'((1 << DIV_SHIFT) / CELL_H);

   localparam logic [COORD_W-1:0] BORDER_C = COORD_W'(BORDER);
   localparam logic [COORD_W-1:0] CELL_W_C = COORD_W'(CELL_W);
   localparam logic [COORD_W-1:0] CELL_H_C = COORD_W'(CELL_H);
   localparam logic [COORD_W-1:0] COLS_C   = COORD_W'(GRID_COLS);
   localparam logic [COORD_W-1:0] ROWS_C   = COORD_W'(GRID_ROWS);
   localparam logic [CMP_W-1:0]   COLS_M   = CMP_W'(GRID_COLS);
   localparam logic [CMP_W-1:0]   ROWS_M   = CMP_W'(GRID_ROWS);

   localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 12'd960;
   localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 12'd540;

   localparam logic [ARGB_W-1:0] WHITE_ARGB = 32'hFFFF_FFFF;

   // Colour for each state code; codes past the end code are blank.
   localparam logic [ARGB_W-1:0] PALETTE [16] = '{
      32'h0000_0000, // off
      32'hFFFF_FFFF, // on
      32'h00FF_0000, // wall
      32'h00FF_00FF, // shortcut
      32'h0080_0080, // exit
      32'h0000_FF00, // hub start
      32'h00FF_C0CB, // hub
      32'h0000_CCCC, // area one
      32'h00C8_6464, // area two
      32'h00FF_FF00, // area three
      32'h009B_FF32, // area four
      32'h0037_9B64, // area five
      32'h00FF_8000, // end
      32'h0000_0000,
      32'h0000_0000,
      32'h0000_0000
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic               is_pixel;
      logic [COL_W-1:0]   cell_col;
      logic [ROW_W-1:0]   cell_row;
      logic [STATE_W-1:0] cell_state;
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
   } item_type;

   typedef struct packed {
      logic               we;
      logic               re;
      logic [ADDR_W-1:0]  addr;
      logic [STATE_W-1:0] wdata;
   } mem_req_type;

   typedef struct packed {
      logic valid;
      logic in_grid;
      logic overlay;
   } pix_tag_type;

endpackage

// ===== design/tgpr_cell_mem.sv =====
// Cell state memory with its clearing pass after reset.
`timescale 1ns / 1ps
`include "tile_grid_pixel_renderer_macros.svh"
module tgpr_cell_mem
   import tgpr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  mem_req_type        req,
   output logic [STATE_W-1:0] rdata,
   output logic               clearing
);

   logic [STATE_W-1:0] mem [STORE_DEPTH];
   logic [STATE_W-1:0] rdata_ff;
   logic               clearing_ff;
   logic               clearing_in;
   logic [ADDR_W-1:0]  clr_addr_ff;
   logic [ADDR_W-1:0]  clr_addr_in;
   logic               clr_last;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [STATE_W-1:0] wr_data;

   assign clr_last = (clr_addr_ff == ADDR_W'(STORE_DEPTH - 1));

   always_comb begin
      clearing_in = clearing_ff && !clr_last;
      clr_addr_in = (clearing_ff && !clr_last) ? clr_addr_ff + 1'b1 : clr_addr_ff;
      wr_en       = clearing_ff || req.we;
      wr_addr     = clearing_ff ? clr_addr_ff : req.addr;
      wr_data     = clearing_ff ? '0 : req.wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (req.re) begin
         rdata_ff <= mem[req.addr];
      end
   end

   assign rdata    = rdata_ff;
   assign clearing = clearing_ff;

   `TGPR_ASSERT_IMP(a_idle_while_clearing, clock, reset, clearing_ff, !(req.we || req.re), "memory request during clearing pass")
   `TGPR_ASSERT_IMP(a_clear_runs_to_end, clock, reset, $fell(clearing_ff), $past(clr_addr_ff) == ADDR_W'(STORE_DEPTH - 1), "clearing pass ended early")
   `TGPR_ASSERT_IMP(a_addr_in_range, clock, reset, req.we || req.re, req.addr <= ADDR_W'(STORE_DEPTH - 1), "memory address past the grid")

endmodule

// ===== design/tgpr_locate.sv =====
// Pixel to grid cell location, overlay test and memory request staging.
`timescale 1ns / 1ps
module tgpr_locate
   import tgpr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  item_type           in_item,
   input  logic [FRAME_W-1:0] frame_width,
   input  logic [FRAME_W-1:0] frame_height,
   output mem_req_type        mem_req,
   output pix_tag_type        pix_tag
);

   // First stage: offsets, quotient estimates and write address.
   logic               x_ge_in, y_ge_in;
   logic [COORD_W-1:0] dx_in, dy_in;
   logic [PROD_W-1:0]  prod_x, prod_y;
   logic               wr_ok_in;
   logic [MUL_W-1:0]   wr_prod;

   logic               s2_valid_ff;
   logic               s2_pixel_ff;
   logic [COORD_W-1:0] s2_x_ff, s2_y_ff;
   logic [COORD_W-1:0] s2_dx_ff, s2_dy_ff;
   logic [COORD_W-1:0] s2_q0x_ff, s2_q0y_ff;
   logic               s2_x_ge_ff, s2_y_ge_ff;
   logic               s2_wr_ok_ff;
   logic [ADDR_W-1:0]  s2_wr_addr_ff;
   logic [STATE_W-1:0] s2_state_ff;

   always_comb begin
      x_ge_in  = in_item.pixel_x >= BORDER_C;
      y_ge_in  = in_item.pixel_y >= BORDER_C;
      dx_in    = in_item.pixel_x - BORDER_C;
      dy_in    = in_item.pixel_y - BORDER_C;
      prod_x   = PROD_W'(dx_in) * PROD_W'(RECIP_X);
      prod_y   = PROD_W'(dy_in) * PROD_W'(RECIP_Y);
      wr_ok_in = (CMP_W'(in_item.cell_col) < COLS_M) && (CMP_W'(in_item.cell_row) < ROWS_M);
      wr_prod  = MUL_W'(in_item.cell_row) * MUL_W'(COLS_M) + MUL_W'(in_item.cell_col);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      s2_pixel_ff   <= in_item.is_pixel;
      s2_x_ff       <= in_item.pixel_x;
      s2_y_ff       <= in_item.pixel_y;
      s2_dx_ff      <= dx_in;
      s2_dy_ff      <= dy_in;
      s2_q0x_ff     <= prod_x[DIV_SHIFT +: COORD_W];
      s2_q0y_ff     <= prod_y[DIV_SHIFT +: COORD_W];
      s2_x_ge_ff    <= x_ge_in;
      s2_y_ge_ff    <= y_ge_in;
      s2_wr_ok_ff   <= wr_ok_in;
      s2_wr_addr_ff <= wr_prod[ADDR_W-1:0];
      s2_state_ff   <= in_item.cell_state;
   end

   // Second stage: correct the quotients and test the overlay.
   logic [COORD_W-1:0] mx, my, r0x, r0y, qx, qy;
   logic               fix_x, fix_y, rx_zero, ry_zero;
   logic [COORD_W:0]   x_far, y_far, w_ext, h_ext;
   logic               in_x, in_y, in_grid_in, overlay_in;

   logic               s3_valid_ff;
   logic               s3_pixel_ff;
   logic [IDX_W-1:0]   s3_qx_ff, s3_qy_ff;
   logic               s3_in_grid_ff;
   logic               s3_overlay_ff;
   logic               s3_wr_ok_ff;
   logic [ADDR_W-1:0]  s3_wr_addr_ff;
   logic [STATE_W-1:0] s3_state_ff;

   always_comb begin
      mx      = s2_q0x_ff * CELL_W_C;
      my      = s2_q0y_ff * CELL_H_C;
      r0x     = s2_dx_ff - mx;
      r0y     = s2_dy_ff - my;
      fix_x   = r0x >= CELL_W_C;
      fix_y   = r0y >= CELL_H_C;
      qx      = fix_x ? s2_q0x_ff + 1'b1 : s2_q0x_ff;
      qy      = fix_y ? s2_q0y_ff + 1'b1 : s2_q0y_ff;
      rx_zero = fix_x ? (r0x == CELL_W_C) : (r0x == '0);
      ry_zero = fix_y ? (r0y == CELL_H_C) : (r0y == '0);

      // x <= w - BORDER is tested as x + BORDER <= w to stay unsigned.
      x_far = {1'b0, s2_x_ff} + {1'b0, BORDER_C};
      y_far = {1'b0, s2_y_ff} + {1'b0, BORDER_C};
      w_ext = {1'b0, frame_width};
      h_ext = {1'b0, frame_height};
      in_x  = s2_x_ge_ff && (x_far <= w_ext);
      in_y  = s2_y_ge_ff && (y_far <= h_ext);

      in_grid_in = s2_x_ge_ff && s2_y_ge_ff && (qx < COLS_C) && (qy < ROWS_C);
      overlay_in = in_x && in_y &&
                   (rx_zero || ry_zero || (x_far == w_ext) || (y_far == h_ext));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_pixel_ff   <= s2_pixel_ff;
      s3_qx_ff      <= qx[IDX_W-1:0];
      s3_qy_ff      <= qy[IDX_W-1:0];
      s3_in_grid_ff <= in_grid_in;
      s3_overlay_ff <= overlay_in;
      s3_wr_ok_ff   <= s2_wr_ok_ff;
      s3_wr_addr_ff <= s2_wr_addr_ff;
      s3_state_ff   <= s2_state_ff;
   end

   // Third stage: form the memory request.
   logic [MUL_W-1:0] pix_prod;
   mem_req_type      mem_req_in;
   pix_tag_type      pix_tag_in;
   mem_req_type      mem_req_ff;
   pix_tag_type      pix_tag_ff;

   always_comb begin
      pix_prod         = MUL_W'(s3_qy_ff) * MUL_W'(COLS_M) + MUL_W'(s3_qx_ff);
      mem_req_in.we    = s3_valid_ff && !s3_pixel_ff && s3_wr_ok_ff;
      mem_req_in.re    = s3_valid_ff && s3_pixel_ff && s3_in_grid_ff;
      mem_req_in.wdata = s3_state_ff;
      if (s3_pixel_ff) begin
         mem_req_in.addr = s3_in_grid_ff ? pix_prod[ADDR_W-1:0] : '0;
      end else begin
         mem_req_in.addr = s3_wr_ok_ff ? s3_wr_addr_ff : '0;
      end
      pix_tag_in.valid   = s3_valid_ff && s3_pixel_ff;
      pix_tag_in.in_grid = s3_in_grid_ff;
      pix_tag_in.overlay = s3_overlay_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_req_ff <= '0;
         pix_tag_ff <= '0;
      end else begin
         mem_req_ff <= mem_req_in;
         pix_tag_ff <= pix_tag_in;
      end
   end

   assign mem_req = mem_req_ff;
   assign pix_tag = pix_tag_ff;

endmodule

// ===== design/tile_grid_pixel_renderer.sv =====
// Top level of the tile grid pixel renderer.
//
//   channel   direction  handshake              word
//   req_*     in         start high, busy low   write a cell state or render a pixel
//   rsp_*     out        rsp_valid, one cycle   rendered ARGB pixel
//   csr_*     in         csr_valid, csr_ready   frame width or frame height
//
// One word is taken in every cycle while busy is low; the path is a register pipeline
// built around one cell memory port, which serves one read or one write a cycle.
// A pixel word passes the input register, the two locate stage registers, the memory
// request register, the memory read register and the output register, which drives rsp_*.
// After reset the memory is swept to the off state one entry a cycle with busy high;
// configuration writes are taken during that time as always.
// The receiver cannot stall: every result is shown for exactly one cycle.
`timescale 1ns / 1ps
`include "tile_grid_pixel_renderer_macros.svh"
module tile_grid_pixel_renderer
   import tgpr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 start,
   output logic                 busy,
   input  logic                 req_func,
   input  logic [COL_W-1:0]     req_cell_col,
   input  logic [ROW_W-1:0]     req_cell_row,
   input  logic [STATE_W-1:0]   req_cell_state,
   input  logic [COORD_W-1:0]   req_pixel_x,
   input  logic [COORD_W-1:0]   req_pixel_y,

   output logic                 rsp_valid,
   output logic [ARGB_W-1:0]    rsp_pixel_argb,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FRAME_W-1:0]   csr_wdata
);

   // Frame registers. Software must write them only while no word is in flight,
   // which the block does not enforce, so the overlay stage may read them directly.
   logic [FRAME_W-1:0] frame_width_ff, frame_width_in;
   logic [FRAME_W-1:0] frame_height_ff, frame_height_in;

   assign csr_ready = 1'b1;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH: begin
               frame_width_in = csr_wdata;
            end
            CSR_FRAME_HEIGHT: begin
               frame_height_in = csr_wdata;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // Input stage. Busy is high only while the memory is being cleared.
   logic     clearing;
   logic     accept;
   logic     s1_valid_ff;
   item_type s1_item_ff;
   item_type s1_item_in;

   assign busy   = clearing;
   assign accept = start && !busy;

   always_comb begin
      s1_item_in.is_pixel   = req_func;
      s1_item_in.cell_col   = req_cell_col;
      s1_item_in.cell_row   = req_cell_row;
      s1_item_in.cell_state = req_cell_state;
      s1_item_in.pixel_x    = req_pixel_x;
      s1_item_in.pixel_y    = req_pixel_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
   end

   // Cell location, overlay test and memory request.
   mem_req_type        mem_req;
   pix_tag_type        pix_tag;
   logic [STATE_W-1:0] cell_rdata;

   tgpr_locate u_locate (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s1_valid_ff),
      .in_item      (s1_item_ff),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .mem_req      (mem_req),
      .pix_tag      (pix_tag)
   );

   // Writes and reads reach the memory in arrival order on a single port, so a
   // read always sees every earlier write and no forwarding path is needed.
   tgpr_cell_mem u_cell_mem (
      .clock    (clock),
      .reset    (reset),
      .req      (mem_req),
      .rdata    (cell_rdata),
      .clearing (clearing)
   );

   // The tag travels one stage alongside the memory read.
   pix_tag_type tag5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag5_ff <= '0;
      end else begin
         tag5_ff <= pix_tag;
      end
   end

   // Palette lookup and overlay into the output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ARGB_W-1:0] rsp_argb_ff, rsp_argb_in;
   logic [ARGB_W-1:0] base_argb;

   always_comb begin
      base_argb    = tag5_ff.in_grid ? PALETTE[cell_rdata] : '0;
      rsp_argb_in  = tag5_ff.overlay ? WHITE_ARGB : base_argb;
      rsp_valid_in = tag5_ff.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_argb_ff <= rsp_argb_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_argb = rsp_argb_ff;

   // The pipeline is six registers deep from the input port to the result port.
   `TGPR_ASSERT_IMP(a_no_result_while_clearing, clock, reset, busy, !rsp_valid, "result during clearing pass")
   `TGPR_ASSERT_LATER(a_pixel_gives_result, clock, reset, accept && req_func, 6, rsp_valid, "pixel word gave no result")
   `TGPR_ASSERT_LATER(a_write_gives_none, clock, reset, accept && !req_func, 6, !rsp_valid, "write word gave a result")
   `TGPR_ASSERT_IMP(a_only_white_opaque, clock, reset, rsp_valid && (rsp_pixel_argb[31:24] != 8'h00), rsp_pixel_argb == WHITE_ARGB, "opaque pixel that is not white")

endmodule

// ===== tb/tile_grid_pixel_renderer_tb.sv =====
// Self-checking testbench for the tile grid pixel renderer: cell writes, pixel reads, overlay.
`timescale 1ns / 1ps
module tile_grid_pixel_renderer_tb;
   import tgpr_pkg::*;

   // Function codes of an input word.
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_PIXEL = 1'b1;

   // State codes used by name in the directed part.
   localparam logic [STATE_W-1:0] ST_OFF       = 4'd0;
   localparam logic [STATE_W-1:0] ST_ON        = 4'd1;
   localparam logic [STATE_W-1:0] ST_WALL      = 4'd2;
   localparam logic [STATE_W-1:0] ST_FINISH    = 4'd12;
   localparam logic [STATE_W-1:0] ST_UNUSED_LO = 4'd13;
   localparam logic [STATE_W-1:0] ST_UNUSED_HI = 4'd15;

   // Run length guard. The slowest legal run is the clearing sweep plus about 1550
   // words with the random gaps of the slow phases and a short drain after each
   // phase, well under the limit.
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 12;
   localparam int PHASE_WORDS   = 254;
   localparam int RECENT_DEPTH  = 16;
   localparam int REPORT_LINES  = 40;

   // Scoreboard: keeps a shadow of the cell store and of the frame registers,
   // predicts the colour of every accepted pixel word and checks results in order.
   class pixel_scoreboard;
      logic [STATE_W-1:0] cell_shadow [STORE_DEPTH];
      logic [ARGB_W-1:0]  state_argb [16];
      logic [ARGB_W-1:0]  expected_argb [$];
      int                 frame_width;
      int                 frame_height;
      int                 mismatch_count;

      function new();
         foreach (cell_shadow[i]) cell_shadow[i] = ST_OFF;
         state_argb = '{
            32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_0000, 32'h00FF_00FF,
            32'h0080_0080, 32'h0000_FF00, 32'h00FF_C0CB, 32'h0000_CCCC,
            32'h00C8_6464, 32'h00FF_FF00, 32'h009B_FF32, 32'h0037_9B64,
            32'h00FF_8000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000
         };
         frame_width    = 960;
         frame_height   = 540;
         mismatch_count = 0;
      endfunction

      task report_mismatch(string msg);
         mismatch_count++;
         if (mismatch_count <= REPORT_LINES)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
      endtask

      function void set_register(logic [CSR_IDX_W-1:0] index, logic [FRAME_W-1:0] data);
         if (index == CSR_FRAME_WIDTH)
            frame_width = int'(data);
         else if (index == CSR_FRAME_HEIGHT)
            frame_height = int'(data);
      endfunction

      function logic [ARGB_W-1:0] render_pixel(int x, int y);
         int                cx;
         int                cy;
         bit                in_x;
         bit                in_y;
         logic [ARGB_W-1:0] colour;
         colour = '0;
         if (x >= BORDER && y >= BORDER) begin
            cx = (x - BORDER) / CELL_W;
            cy = (y - BORDER) / CELL_H;
            if (cx < GRID_COLS && cy < GRID_ROWS)
               colour = state_argb[cell_shadow[cy * GRID_COLS + cx]];
         end
         in_x = (x >= BORDER) && (x <= frame_width - BORDER);
         in_y = (y >= BORDER) && (y <= frame_height - BORDER);
         if (in_x && in_y &&
             (((x - BORDER) % CELL_W) == 0 || ((y - BORDER) % CELL_H) == 0 ||
              x == frame_width - BORDER || y == frame_height - BORDER))
            colour = 32'hFFFF_FFFF;
         return colour;
      endfunction

      function void note_word(logic func, logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                              logic [STATE_W-1:0] st, logic [COORD_W-1:0] px,
                              logic [COORD_W-1:0] py);
         if (func == FUNC_WRITE) begin
            if (int'(col) < GRID_COLS && int'(row) < GRID_ROWS)
               cell_shadow[int'(row) * GRID_COLS + int'(col)] = st;
         end else begin
            expected_argb.push_back(render_pixel(int'(px), int'(py)));
         end
      endfunction

      task check_result(logic [ARGB_W-1:0] argb);
         logic [ARGB_W-1:0] want;
         if (expected_argb.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel_argb %08h", argb));
         end else begin
            want = expected_argb.pop_front();
            if (argb !== want)
               report_mismatch($sformatf("pixel_argb got %08h want %08h", argb, want));
         end
      endtask

      function int pending_count();
         return expected_argb.size();
      endfunction
   endclass

   typedef struct {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } cell_pos_type;

   // Every block input has a known value from time zero.
   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 start          = 1'b0;
   logic                 busy;
   logic                 req_func       = FUNC_WRITE;
   logic [COL_W-1:0]     req_cell_col   = '0;
   logic [ROW_W-1:0]     req_cell_row   = '0;
   logic [STATE_W-1:0]   req_cell_state = '0;
   logic [COORD_W-1:0]   req_pixel_x    = '0;
   logic [COORD_W-1:0]   req_pixel_y    = '0;
   logic                 rsp_valid;
   logic [ARGB_W-1:0]    rsp_pixel_argb;
   logic                 csr_valid      = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index      = '0;
   logic [FRAME_W-1:0]   csr_wdata      = '0;

   pixel_scoreboard sb = new();

   int           cycle_count     = 0;
   int           sender_idle_pct = 0;
   int           cur_width       = 960;
   int           cur_height      = 540;
   cell_pos_type recent_cells [$];

   tile_grid_pixel_renderer DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_cell_col   (req_cell_col),
      .req_cell_row   (req_cell_row),
      .req_cell_state (req_cell_state),
      .req_pixel_x    (req_pixel_x),
      .req_pixel_y    (req_pixel_y),
      .rsp_valid      (rsp_valid),
      .rsp_pixel_argb (rsp_pixel_argb),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Cycle counter and watchdog. If the run has not ended by the limit, a word
   // was never accepted or a result never came, so the run is a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Monitor. Inputs are driven with nonblocking assignments at the edge, so the
   // values read here are the ones the block sees at this same edge. A word is
   // taken when start is high and busy is low; a result is taken whenever the
   // strobe is high, since the receiver has no way to hold it off.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.set_register(csr_index, csr_wdata);
         if (start && !busy)
            sb.note_word(req_func, req_cell_col, req_cell_row, req_cell_state,
                         req_pixel_x, req_pixel_y);
         if (rsp_valid)
            sb.check_result(rsp_pixel_argb);
      end
   end

   // Presents one word and holds it until the block takes it. Afterwards the
   // sender may leave a random gap; start is lowered only when a gap follows, so
   // back-to-back words keep start high without a glitch in the same step.
   task automatic send_word(logic func, logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                            logic [STATE_W-1:0] st, logic [COORD_W-1:0] px,
                            logic [COORD_W-1:0] py);
      start          <= 1'b1;
      req_func       <= func;
      req_cell_col   <= col;
      req_cell_row   <= row;
      req_cell_state <= st;
      req_pixel_x    <= px;
      req_pixel_y    <= py;
      @(posedge clock);
      while (busy) @(posedge clock);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
   endtask

   task automatic write_cell(logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                             logic [STATE_W-1:0] st);
      send_word(FUNC_WRITE, col, row, st, COORD_W'($urandom), COORD_W'($urandom));
   endtask

   task automatic read_pixel(int x, int y);
      send_word(FUNC_PIXEL, COL_W'($urandom), ROW_W'($urandom), STATE_W'($urandom),
                COORD_W'(x), COORD_W'(y));
   endtask

   // Writes one frame register. The valid is dropped once the write is taken and the
   // task returns after an edge with it low, so a following write starts in a later step.
   task automatic write_register(csr_index_type index, logic [FRAME_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stops the sender and waits until every predicted pixel has come back, then
   // lets the pipeline run empty so a trailing write has surely landed too.
   task automatic drain_pipeline();
      start <= 1'b0;
      while (sb.pending_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One random word. Most writes land inside the grid and are remembered, so
   // that many pixel reads can target a cell that was just written, sometimes in
   // the very next cycle. Other reads sweep the grid area, hug the frame edges
   // where the overlay lines fall, or use the full coordinate range.
   task automatic random_word();
      int                 kind;
      int                 x;
      int                 y;
      cell_pos_type       pos;
      logic [COL_W-1:0]   col;
      logic [ROW_W-1:0]   row;
      kind = $urandom_range(0, 99);
      col  = COL_W'($urandom);
      row  = ROW_W'($urandom);
      if (kind < 35) begin
         if ($urandom_range(0, 9) != 0) begin
            col = COL_W'($urandom_range(0, GRID_COLS - 1));
            row = ROW_W'($urandom_range(0, GRID_ROWS - 1));
            pos.col = col;
            pos.row = row;
            recent_cells.push_back(pos);
            if (recent_cells.size() > RECENT_DEPTH)
               void'(recent_cells.pop_front());
         end
         write_cell(col, row, STATE_W'($urandom));
      end else begin
         if (kind < 65 && recent_cells.size() != 0) begin
            pos = recent_cells[$urandom_range(0, recent_cells.size() - 1)];
            x = BORDER + int'(pos.col) * CELL_W + int'($urandom_range(0, CELL_W - 1));
            y = BORDER + int'(pos.row) * CELL_H + int'($urandom_range(0, CELL_H - 1));
         end else if (kind < 82) begin
            x = $urandom_range(0, GRID_COLS * CELL_W + 2 * BORDER);
            y = $urandom_range(0, GRID_ROWS * CELL_H + 2 * BORDER);
         end else if (kind < 90) begin
            // Around the right and bottom overlay edges of the current frame.
            x = cur_width - BORDER + int'($urandom_range(0, 2)) - 1;
            y = cur_height - BORDER + int'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1) == 0)
               x = $urandom_range(0, 4095);
            else
               y = $urandom_range(0, 4095);
         end else begin
            x = $urandom_range(0, 4095);
            y = $urandom_range(0, 4095);
         end
         read_pixel(x, y);
      end
   endtask

   // Frame settings for the random phases, the extremes among them.
   int phase_width  [6] = '{4095, 1,  10, 960, 0,   511};
   int phase_height [6] = '{4095, 1,  20, 540, 0,   300};

   initial begin
      // Synchronous reset, held from time zero and never asserted again once released.
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset frame of 960 by 540. The block clears its
      // store after reset with busy high, so the first word simply waits. Words
      // go back to back so that reads follow writes without a gap.
      sender_idle_pct = 0;
      write_cell(7'd0,  6'd0,  ST_ON);
      write_cell(7'd93, 6'd51, ST_FINISH);
      write_cell(7'd94, 6'd0,  ST_WALL);       // column past the grid, ignored
      write_cell(7'd0,  6'd52, ST_WALL);       // row past the grid, ignored
      write_cell(7'd127, 6'd63, ST_ON);        // both fields at their top, ignored
      write_cell(7'd1,  6'd0,  ST_UNUSED_LO);
      write_cell(7'd2,  6'd0,  ST_UNUSED_HI);
      write_cell(7'd3,  6'd0,  ST_WALL);
      read_pixel(15, 15);                      // opaque on cell
      read_pixel(945, 525);                    // last cell of the grid
      read_pixel(25, 15);                      // unused codes give blank colour
      read_pixel(35, 15);
      read_pixel(45, 15);
      read_pixel(10, 10);                      // first grid line corner
      read_pixel(0, 0);                        // inside the border
      read_pixel(5, 15);
      read_pixel(4095, 4095);                  // far past the grid
      read_pixel(4095, 15);
      read_pixel(15, 4095);
      read_pixel(950, 15);                     // right frame edge line
      read_pixel(951, 15);                     // past the frame and the grid
      read_pixel(15, 530);                     // bottom frame edge line
      read_pixel(949, 529);                    // inner corner of the last cell
      write_cell(7'd93, 6'd51, ST_OFF);
      read_pixel(945, 525);

      // Random phases. Before each one the pipeline is drained, which also keeps
      // the sender paused until every expected word is back, and the frame is
      // reprogrammed while the block is idle.
      for (int phase = 0; phase < 6; phase++) begin
         drain_pipeline();
         cur_width  = (phase_width[phase]  == 0) ? int'($urandom_range(1, 4095))
                                                  : phase_width[phase];
         cur_height = (phase_height[phase] == 0) ? int'($urandom_range(1, 4095))
                                                  : phase_height[phase];
         write_register(CSR_FRAME_WIDTH,  FRAME_W'(cur_width));
         write_register(CSR_FRAME_HEIGHT, FRAME_W'(cur_height));
         // Sender idles lightly first, then heavily, then not at all.
         sender_idle_pct = (phase < 2) ? 7 : (phase < 4) ? 80 : 0;
         for (int n = 0; n < PHASE_WORDS; n++)
            random_word();
      end

      drain_pipeline();
      if (sb.pending_count() != 0)
         sb.report_mismatch($sformatf("%0d pixel words never answered", sb.pending_count()));
      if (sb.mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
